@@ rtl/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants for the shared power-enable reference counter.
// ----------------------------------------------------------------------------
package spe_pkg;

	// Slot table geometry
	localparam int PINS    = 48;
	localparam int IDX_W   = (PINS > 1) ? $clog2(PINS) : 1;
	localparam int PIN_W   = 8;
	localparam int CNT_W   = 8;
	localparam int STAMP_W = 32;
	localparam int ENTRY_W = CNT_W + STAMP_W;
	localparam int LEVEL_W = 48;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Request kinds
	typedef enum logic [2:0] {
		REQ_REGISTER = 3'd0,
		REQ_ACQUIRE  = 3'd1,
		REQ_RELEASE  = 3'd2,
		REQ_QUERY    = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_kind_t;

	// Status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_PIN = 1'b1;

	// One slot entry as stored in the table memory
	typedef struct packed {
		logic [CNT_W-1:0]   cnt;
		logic [STAMP_W-1:0] stamp;
	} slot_entry_t;

	// Per-pin flag vectors kept in flops
	typedef struct packed {
		logic [PINS-1:0] pol;
		logic [PINS-1:0] regd;
		logic [PINS-1:0] on;
		logic [PINS-1:0] drv;
	} slot_vec_t;

	// Table write-back control from the update logic
	typedef struct packed {
		logic        wr_en;
		logic        clear;
		slot_entry_t entry;
	} slot_upd_t;

endpackage

@@ rtl/spe_ram.sv @@
// ----------------------------------------------------------------------------
// spe_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module spe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/spe_update.sv @@
// ----------------------------------------------------------------------------
// spe_update
// Modify step of the read-modify-write: applies one request word to the
// slot entry read from the table and to the per-pin flag vectors.
// ----------------------------------------------------------------------------
module spe_update (
	input  spe_pkg::req_kind_t            kind,
	input  logic                          pin_ok,
	input  logic [spe_pkg::IDX_W-1:0]     idx,
	input  logic                          low,
	input  logic [spe_pkg::STAMP_W-1:0]   now_ms,
	input  spe_pkg::slot_entry_t          entry,
	input  spe_pkg::slot_vec_t            vec,
	output spe_pkg::slot_vec_t            vec_nxt,
	output spe_pkg::slot_upd_t            upd,
	output logic                          status,
	output logic [spe_pkg::STAMP_W-1:0]   on_time
);

	import spe_pkg::*;

	logic [PINS-1:0] held;
	logic            pin_kind;

	assign held     = vec.regd & vec.on;
	assign pin_kind = (kind == REQ_REGISTER) || (kind == REQ_ACQUIRE) ||
	                  (kind == REQ_RELEASE)  || (kind == REQ_QUERY);

	// Request decode and state update
	always_comb begin
		vec_nxt   = vec;
		upd.wr_en = 1'b0;
		upd.clear = 1'b0;
		upd.entry = entry;
		status    = STATUS_OK;
		on_time   = '0;
		if (pin_kind && !pin_ok) begin
			status = STATUS_BAD_PIN;
		end else begin
			case (kind)
				REQ_REGISTER: begin
					vec_nxt.pol[idx] = low;
					// first registration parks the pin inactive
					if (!vec.regd[idx]) begin
						vec_nxt.drv[idx]  = low;
						vec_nxt.on[idx]   = 1'b0;
						vec_nxt.regd[idx] = 1'b1;
						upd.entry.cnt     = '0;
						upd.wr_en         = 1'b1;
					end
				end
				REQ_ACQUIRE: begin
					upd.wr_en = 1'b1;
					if (entry.cnt == '0) begin
						vec_nxt.drv[idx] = ~vec.pol[idx];
						vec_nxt.on[idx]  = 1'b1;
						upd.entry.stamp  = now_ms;
					end
					if (entry.cnt != CNT_MAX) begin
						upd.entry.cnt = entry.cnt + CNT_W'(1);
					end
				end
				REQ_RELEASE: begin
					// release at zero count is ignored
					if (entry.cnt != '0) begin
						upd.wr_en     = 1'b1;
						upd.entry.cnt = entry.cnt - CNT_W'(1);
						if (entry.cnt == CNT_W'(1)) begin
							vec_nxt.drv[idx] = vec.pol[idx];
							vec_nxt.on[idx]  = 1'b0;
						end
					end
				end
				REQ_QUERY: begin
					on_time = entry.stamp;
				end
				REQ_CLEAR: begin
					// held, registered pins go to their inactive level
					vec_nxt.drv  = (vec.drv & ~held) | (held & vec.pol);
					vec_nxt.pol  = '0;
					vec_nxt.regd = '0;
					vec_nxt.on   = '0;
					upd.clear    = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/shared_power_enable_refcount.sv @@
// ----------------------------------------------------------------------------
// shared_power_enable_refcount
// Reference-counted power enables for a table of shared pins.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req_valid/req_stall with req_type, pin,
//   on_low and now_ms. Each request gives exactly one response word on
//   rsp_valid/rsp_stall: status, on_time and the pin level and on-state
//   vectors as they stand after the request.
//   Hold counts and on-time stamps live in one 48-entry table RAM with a
//   registered read; each request is a read at acceptance and a write-back
//   in its modify cycle. Polarity, registration, on and level flags
//   sit in flops, and each table entry has a valid flop so unwritten or
//   cleared entries read as zero; clear-all therefore needs no table pass.
//   The response word passes the table read, the modify stage and the
//   output register; a new request is taken only once the one before
//   has left the modify stage, so table read-modify-writes never overlap.
//   req_stall is high while a request is in its modify cycle; the next
//   request is taken while a response still waits in the output register.
//   A stalled response holds, and the request in flight waits behind it.
//   Reset clears every flag, all entry valid bits and both valid stages;
//   no clearing pass follows, so requests are taken right after reset.
// ----------------------------------------------------------------------------
module shared_power_enable_refcount (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [2:0]                    req_type,
	input  logic signed [spe_pkg::PIN_W-1:0] pin,
	input  logic                          on_low,
	input  logic [spe_pkg::STAMP_W-1:0]   now_ms,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          status,
	output logic [spe_pkg::STAMP_W-1:0]   on_time,
	output logic [spe_pkg::LEVEL_W-1:0]   pin_levels,
	output logic [spe_pkg::LEVEL_W-1:0]   power_on_mask
);

	import spe_pkg::*;

	// input decode
	logic              req_acc;
	logic              pin_ok_in;
	logic [IDX_W-1:0]  idx_in;

	// modify stage
	logic              valid_s1;
	req_kind_t         kind_s1;
	logic              pin_ok_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              low_s1;
	logic [STAMP_W-1:0] now_s1;
	logic              hit_s1;
	logic              fire;

	// table and flags
	logic [ENTRY_W-1:0] ram_rdata;
	slot_entry_t       entry_eff;
	logic [PINS-1:0]   entry_valid_q;
	slot_vec_t         vec_q;
	slot_vec_t         vec_nxt;
	slot_upd_t         upd;
	logic              status_nxt;
	logic [STAMP_W-1:0] on_time_nxt;

	// response register
	logic              rsp_valid_q;
	logic              status_q;
	logic [STAMP_W-1:0] on_time_q;
	logic [LEVEL_W-1:0] levels_q;
	logic [LEVEL_W-1:0] mask_q;

	// Input acceptance; one request in flight at a time
	assign req_stall = valid_s1;
	assign req_acc   = req_valid && !valid_s1;
	assign pin_ok_in = $unsigned(pin) < PIN_W'(PINS);
	assign idx_in    = pin_ok_in ? IDX_W'($unsigned(pin)) : '0;

	// Modify stage advances when the response register is free
	assign fire = valid_s1 && (!rsp_valid_q || !rsp_stall);

	// Table memory: count and on-time stamp per slot
	spe_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PINS)
	) u_table (
		.clk     (clk),
		.wr_en   (fire && upd.wr_en),
		.wr_addr (idx_s1),
		.wr_data (upd.entry),
		.rd_en   (req_acc),
		.rd_addr (idx_in),
		.rd_data (ram_rdata)
	);

	// Entries never written since reset or clear read as zero
	assign entry_eff = hit_s1 ? slot_entry_t'(ram_rdata) : '0;

	spe_update u_update (
		.kind    (kind_s1),
		.pin_ok  (pin_ok_s1),
		.idx     (idx_s1),
		.low     (low_s1),
		.now_ms  (now_s1),
		.entry   (entry_eff),
		.vec     (vec_q),
		.vec_nxt (vec_nxt),
		.upd     (upd),
		.status  (status_nxt),
		.on_time (on_time_nxt)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, captured with the table read
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_s1   <= req_kind_t'(req_type);
			pin_ok_s1 <= pin_ok_in;
			idx_s1    <= idx_in;
			low_s1    <= on_low;
			now_s1    <= now_ms;
			hit_s1    <= entry_valid_q[idx_in];
		end
	end

	// Flag vectors and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q         <= '0;
			entry_valid_q <= '0;
		end else if (fire) begin
			vec_q <= vec_nxt;
			if (upd.clear) begin
				entry_valid_q <= '0;
			end else if (upd.wr_en) begin
				entry_valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Response register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_nxt;
			on_time_q <= on_time_nxt;
			levels_q  <= LEVEL_W'(vec_nxt.drv);
			mask_q    <= LEVEL_W'(vec_nxt.on);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign on_time       = on_time_q;
	assign pin_levels    = levels_q;
	assign power_on_mask = mask_q;

	// A slot is only on if its table entry has been written
	a_on_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_q.on & ~entry_valid_q) == '0)
		else $error("slot on without a valid table entry");

	// Clear-all wipes every flag except the driven levels
	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_s1 == REQ_CLEAR) |=>
		(vec_q.on == '0 && vec_q.regd == '0 && vec_q.pol == '0 &&
		 entry_valid_q == '0))
		else $error("clear left state behind");

	// A rejected pin changes no flag
	a_bad_pin_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status_nxt == STATUS_BAD_PIN) |=>
		($stable(vec_q) && $stable(entry_valid_q)))
		else $error("rejected request changed state");

	// A response appears only after a modify cycle
	a_rsp_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(fire))
		else $error("response without a request");

endmodule
